@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, types and tables for the great-circle distance block.
// ----------------------------------------------------------------------------
package gcd_pkg;
    localparam int CordicIterations = 24;
    localparam int Iters = (CordicIterations < 32) ? CordicIterations : 32;
    localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
    localparam logic signed [35:0] GainQ30 = 36'sd652032874;
    localparam logic signed [35:0] HalfTurn = 36'sd1800000000;
    localparam logic signed [35:0] FullTurn = 36'sd3600000000;
    localparam logic signed [35:0] QuarterTurn = 36'sd900000000;

    typedef logic signed [35:0] ang_t;
    typedef logic signed [35:0] val_t;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0: r = 36'sh03243F6A8;  5'd1: r = 36'sh01DAC6705;
            5'd2: r = 36'sh00FADBAFC;  5'd3: r = 36'sh007F56EA6;
            5'd4: r = 36'sh003FEAB76;  5'd5: r = 36'sh001FFD55B;
            5'd6: r = 36'sh000FFFAAA;  5'd7: r = 36'sh0007FFF55;
            5'd8: r = 36'sh0003FFFEA;  5'd9: r = 36'sh0001FFFFD;
            5'd10: r = 36'sh0000FFFFF; 5'd11: r = 36'sh00007FFFF;
            5'd12: r = 36'sh00003FFFF; 5'd13: r = 36'sh00001FFFF;
            5'd14: r = 36'sh00000FFFF; 5'd15: r = 36'sh000007FFF;
            5'd16: r = 36'sh000003FFF; 5'd17: r = 36'sh000001FFF;
            5'd18: r = 36'sh000000FFF; 5'd19: r = 36'sh0000007FF;
            5'd20: r = 36'sh0000003FF; 5'd21: r = 36'sh0000001FF;
            5'd22: r = 36'sh0000000FF; 5'd23: r = 36'sh00000007F;
            5'd24: r = 36'sh00000003F; 5'd25: r = 36'sh00000001F;
            5'd26: r = 36'sh00000000F; 5'd27: r = 36'sh000000008;
            5'd28: r = 36'sh000000004; 5'd29: r = 36'sh000000002;
            5'd30: r = 36'sh000000001; default: r = 36'sh000000000;
        endcase
        return r;
    endfunction
endpackage

@@ hw/rtl/gcd_if.sv @@
// ----------------------------------------------------------------------------
// gcd_in_if / gcd_out_if
// Valid/ready channels carrying position pairs and distances.
// ----------------------------------------------------------------------------
interface gcd_in_if;
    logic valid;
    logic ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if;
    logic valid;
    logic ready;
    logic [29:0] distance_miles;
    modport source (output valid, distance_miles, input ready);
    modport sink (input valid, distance_miles, output ready);
endinterface

@@ hw/rtl/great_circle_distance.sv @@
// ----------------------------------------------------------------------------
// great_circle_distance
// Spherical law of cosines distance between two positions, in miles.
// ----------------------------------------------------------------------------
// Accepts one position pair per clock and returns one distance per pair,
// in order, in units of 1/65536 statute mile. The datapath is a single
// stall-together pipeline of 2*iterations + 48 stages. It runs in this order:
// - angle reduction and conversion to radians (6 stages);
// - a row of rotation CORDIC cells for the sine and cosine of both latitudes
//   and of the longitude difference;
// - the cosine product (4 stages);
// - clamp and y^2 (1 stage);
// - a 32-step square-root row;
// - a row of vectoring CORDIC cells for the arccosine;
// - a final scale (5 stages).
// Both divisions by a constant use a reciprocal multiply followed by one
// compare-and-subtract fix-up. Throughput is one item per cycle while the
// output is taken. A full pipeline holds when the output stalls; no item
// is dropped.
module great_circle_distance (
    input logic clk,
    input logic rst_n,
    gcd_in_if.sink in_ch,
    gcd_out_if.source out_ch
);
    localparam int N = gcd_pkg::Iters;
    localparam int Depth = 6 + N + 4 + 1 + 32 + N + 5;

    // one valid bit per pipeline stage; the whole pipe advances together
    logic [Depth-1:0] vld_reg;
    logic adv;
    assign adv = !vld_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], in_ch.valid};
    end

    // ---- reduction stage 1: longitude difference
    logic signed [35:0] a1_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg[0] <= 36'(in_ch.lat_a);
            a1_reg[1] <= 36'(in_ch.lat_b);
            a1_reg[2] <= 36'(in_ch.lon_a) - 36'(in_ch.lon_b);
        end
    end

    // ---- stage 2: fold into [-90,90] deg, sign flag
    // inputs stay within +-2^32, so one add or subtract of a full turn
    // lands in (-360,360); a second fold lands in (-180,180]
    logic signed [35:0] a2_reg [3];
    logic [2:0] neg2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [35:0] r;
                logic flip;
                r = a1_reg[k];
                flip = 1'b0;
                if (r >= gcd_pkg::FullTurn) r = r - gcd_pkg::FullTurn;
                if (r <= -gcd_pkg::FullTurn) r = r + gcd_pkg::FullTurn;
                if (r < 0) r = r + gcd_pkg::FullTurn;
                if (r > gcd_pkg::HalfTurn) r = r - gcd_pkg::FullTurn;
                if (r > gcd_pkg::QuarterTurn)
                begin
                    r = r - gcd_pkg::HalfTurn;
                    flip = 1'b1;
                end
                else if (r < -gcd_pkg::QuarterTurn)
                begin
                    r = r + gcd_pkg::HalfTurn;
                    flip = 1'b1;
                end
                neg2_reg[k] <= flip;
                a2_reg[k] <= r;
            end
        end
    end

    // ---- stages 3 to 6: radians Q30 = round(|d|*pi/1.8e9)
    // The reciprocal multiply on the top numerator bits gives a quotient
    // that is low by at most two; the remainder compare fixes it up.
    localparam logic [31:0] DegRecip = 32'd2562047788;
    localparam logic [63:0] DegDiv = 64'd1800000000;
    localparam logic [63:0] DegDiv2 = 64'd3600000000;
    logic [63:0] dnum_reg [3];
    logic [63:0] dnum2_reg [3];
    logic [31:0] dq_reg [3];
    logic [31:0] dq2_reg [3];
    logic [63:0] drem_reg [3];
    logic [2:0] dsg_reg, dsg2_reg, dsg3_reg;
    logic [2:0] neg_a_reg, neg_b_reg, neg_c_reg;
    gcd_pkg::ang_t z0_reg [3];
    logic [2:0] neg3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_a_reg <= neg2_reg;
            neg_b_reg <= neg_a_reg;
            neg_c_reg <= neg_b_reg;
            neg3_reg <= neg_c_reg;
            dsg2_reg <= dsg_reg;
            dsg3_reg <= dsg2_reg;
            for (int k = 0; k < 3; k++)
            begin
                logic [29:0] m;
                logic [31:0] q;
                m = a2_reg[k][35] ? 30'(-a2_reg[k]) : 30'(a2_reg[k]);
                dsg_reg[k] <= a2_reg[k][35];
                dnum_reg[k] <= 64'(m) * 64'd3373259426 + 64'd900000000;
                dq_reg[k] <= 32'((64'(dnum_reg[k][61:30]) * 64'(DegRecip)) >> 32);
                dnum2_reg[k] <= dnum_reg[k];
                drem_reg[k] <= dnum2_reg[k] - 64'(dq_reg[k]) * DegDiv;
                dq2_reg[k] <= dq_reg[k];
                q = dq2_reg[k];
                if (drem_reg[k] >= DegDiv2) q = q + 32'd2;
                else if (drem_reg[k] >= DegDiv) q = q + 32'd1;
                z0_reg[k] <= dsg3_reg[k] ? -36'(q) : 36'(q);
            end
        end
    end

    // ---- rotation CORDIC row
    gcd_pkg::val_t rx [N+1][3];
    gcd_pkg::val_t ry [N+1][3];
    gcd_pkg::ang_t rz [N+1][3];
    logic [2:0] rneg [N+1];
    logic [2:0] rneg_reg [N];
    assign rneg[0] = neg3_reg;
    for (genvar k = 0; k < 3; k++)
    begin : g_init
        assign rx[0][k] = gcd_pkg::GainQ30;
        assign ry[0][k] = '0;
        assign rz[0][k] = z0_reg[k];
    end
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        gcd_rot_cell u_cell (
            .clk(clk), .shift(5'(i)), .en(adv),
            .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
            .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv) rneg_reg[i] <= rneg[i];
        end
        assign rneg[i+1] = rneg_reg[i];
    end

    // ---- cosine product, 4 stages; sines and cosines fit 32 bits signed
    logic signed [31:0] sa_reg, ca_reg, sb_reg, cb_reg, cd_reg;
    logic signed [63:0] cab_reg, sab_reg;
    logic signed [31:0] cd2_reg;
    logic signed [31:0] cabr_reg;
    logic signed [63:0] sab2_reg;
    logic signed [31:0] cd3_reg;
    logic signed [73:0] c_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg <= 32'(rneg[N][0] ? -ry[N][0] : ry[N][0]);
            ca_reg <= 32'(rneg[N][0] ? -rx[N][0] : rx[N][0]);
            sb_reg <= 32'(rneg[N][1] ? -ry[N][1] : ry[N][1]);
            cb_reg <= 32'(rneg[N][1] ? -rx[N][1] : rx[N][1]);
            cd_reg <= 32'(rneg[N][2] ? -rx[N][2] : rx[N][2]);
            cab_reg <= 64'(ca_reg) * 64'(cb_reg);
            sab_reg <= 64'(sa_reg) * 64'(sb_reg);
            cd2_reg <= cd_reg;
            cabr_reg <= cab_reg[63] ? -32'(((-cab_reg) + 64'sd536870912) >>> 30)
                                    : 32'((cab_reg + 64'sd536870912) >>> 30);
            sab2_reg <= sab_reg;
            cd3_reg <= cd2_reg;
            c_reg <= 74'(sab2_reg) + 74'(64'(cabr_reg) * 64'(cd3_reg));
        end
    end

    // clamp, y^2, CORDIC x
    localparam logic signed [73:0] One60 = 74'sd1 <<< 60;
    logic signed [73:0] cc;
    logic [63:0] om, op, fa, fb, y2;
    logic signed [35:0] xr;
    always_comb
    begin
        cc = c_reg;
        if (cc > One60) cc = One60;
        if (cc < -One60) cc = -One60;
        om = 64'(One60 - cc);
        op = 64'(One60 + cc);
        if (op >= om) begin fa = om; fb = op >> 31; end
        else begin fa = op; fb = om >> 31; end
        y2 = ((64'(fa >> 31) * fb) << 2) + ((64'(fa[30:0]) * fb) >> 29);
        xr = cc[73] ? -36'(((-cc) + 74'sd536870912) >>> 30)
                    : 36'((cc + 74'sd536870912) >>> 30);
    end

    logic [63:0] y2_reg;
    gcd_pkg::val_t xq_reg;
    logic flipq_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y2_reg <= y2;
            xq_reg <= xr[35] ? -xr : xr;
            flipq_reg <= xr[35];
        end
    end

    // ---- square-root row (bit starts at 4^31)
    logic [63:0] srem [33];
    logic [63:0] sres [33];
    gcd_pkg::val_t sx [33];
    logic sflip [33];
    assign srem[0] = y2_reg;
    assign sres[0] = '0;
    assign sx[0] = xq_reg;
    assign sflip[0] = flipq_reg;
    for (genvar j = 0; j < 32; j++)
    begin : g_sqrt
        gcd_sqrt_cell u_cell (
            .clk(clk), .step(6'(31 - j)), .en(adv),
            .rem_in(srem[j]), .res_in(sres[j]), .x_in(sx[j]), .flip_in(sflip[j]),
            .rem_out(srem[j+1]), .res_out(sres[j+1]), .x_out(sx[j+1]),
            .flip_out(sflip[j+1])
        );
    end

    // ---- vectoring CORDIC row
    gcd_pkg::val_t vx [N+1];
    gcd_pkg::val_t vy [N+1];
    gcd_pkg::ang_t vz [N+1];
    logic vf [N+1];
    assign vx[0] = sx[32];
    assign vy[0] = 36'(sres[32]);
    assign vz[0] = '0;
    assign vf[0] = sflip[32];
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        gcd_vec_cell u_cell (
            .clk(clk), .shift(5'(i)), .en(adv),
            .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]), .flip_in(vf[i]),
            .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]), .flip_out(vf[i+1])
        );
    end

    // ---- final scale, 5 stages: miles = round(theta*124362*32768 / (5*pi))
    // same reciprocal estimate and fix-up as the radians conversion
    localparam logic [31:0] MileRecip = 32'd1093704440;
    localparam logic [63:0] MileDiv = 64'd16866297130;
    localparam logic [63:0] MileDiv2 = 64'd33732594260;
    gcd_pkg::ang_t th_reg;
    logic [63:0] prod_reg, prod2_reg, mrem_reg;
    logic [31:0] mq_reg, mq2_reg;
    logic [29:0] miles_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gcd_pkg::ang_t t;
            logic [31:0] q;
            t = vf[N] ? gcd_pkg::PiQ30 - vz[N] : vz[N];
            if (t < 0) t = '0;
            if (t > gcd_pkg::PiQ30) t = gcd_pkg::PiQ30;
            th_reg <= t;
            prod_reg <= 64'(th_reg[31:0]) * 64'd4075094016 + 64'd8433148565;
            mq_reg <= 32'((64'(prod_reg[63:32]) * 64'(MileRecip)) >> 32);
            prod2_reg <= prod_reg;
            mrem_reg <= prod2_reg - 64'(mq_reg) * MileDiv;
            mq2_reg <= mq_reg;
            q = mq2_reg;
            if (mrem_reg >= MileDiv2) q = q + 32'd2;
            else if (mrem_reg >= MileDiv) q = q + 32'd1;
            miles_reg <= 30'(q);
        end
    end

    assign out_ch.valid = vld_reg[Depth-1];
    assign out_ch.distance_miles = miles_reg;
endmodule

@@ hw/rtl/gcd_rot_cell.sv @@
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One rotation-mode CORDIC micro-rotation for three angles, registered.
// ----------------------------------------------------------------------------
module gcd_rot_cell (
    input  logic clk,
    input  logic [4:0] shift,
    input  logic en,
    input  gcd_pkg::val_t x_in [3],
    input  gcd_pkg::val_t y_in [3],
    input  gcd_pkg::ang_t z_in [3],
    output gcd_pkg::val_t x_out [3],
    output gcd_pkg::val_t y_out [3],
    output gcd_pkg::ang_t z_out [3]
);
    gcd_pkg::val_t x_reg [3];
    gcd_pkg::val_t y_reg [3];
    gcd_pkg::ang_t z_reg [3];
    gcd_pkg::ang_t at;

    assign at = gcd_pkg::atan_q30(shift);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!z_in[k][35])
                begin
                    x_reg[k] <= x_in[k] - (y_in[k] >>> shift);
                    y_reg[k] <= y_in[k] + (x_in[k] >>> shift);
                    z_reg[k] <= z_in[k] - at;
                end
                else
                begin
                    x_reg[k] <= x_in[k] + (y_in[k] >>> shift);
                    y_reg[k] <= y_in[k] - (x_in[k] >>> shift);
                    z_reg[k] <= z_in[k] + at;
                end
            end
        end
    end
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

@@ hw/rtl/gcd_vec_cell.sv @@
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One vectoring-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module gcd_vec_cell (
    input  logic clk,
    input  logic [4:0] shift,
    input  logic en,
    input  gcd_pkg::val_t x_in,
    input  gcd_pkg::val_t y_in,
    input  gcd_pkg::ang_t z_in,
    input  logic flip_in,
    output gcd_pkg::val_t x_out,
    output gcd_pkg::val_t y_out,
    output gcd_pkg::ang_t z_out,
    output logic flip_out
);
    gcd_pkg::val_t x_reg, y_reg;
    gcd_pkg::ang_t z_reg, at;
    logic flip_reg;

    assign at = gcd_pkg::atan_q30(shift);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg <= flip_in;
            if (!y_in[35])
            begin
                x_reg <= x_in + (y_in >>> shift);
                y_reg <= y_in - (x_in >>> shift);
                z_reg <= z_in + at;
            end
            else
            begin
                x_reg <= x_in - (y_in >>> shift);
                y_reg <= y_in + (x_in >>> shift);
                z_reg <= z_in - at;
            end
        end
    end
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign flip_out = flip_reg;
endmodule

@@ hw/rtl/gcd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One restoring square-root step (two radicand bits), registered, with
// the side data that travels alongside.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell (
    input  logic clk,
    input  logic [5:0] step,
    input  logic en,
    input  logic [63:0] rem_in,
    input  logic [63:0] res_in,
    input  gcd_pkg::val_t x_in,
    input  logic flip_in,
    output logic [63:0] rem_out,
    output logic [63:0] res_out,
    output gcd_pkg::val_t x_out,
    output logic flip_out
);
    logic [63:0] rem_reg, res_reg, bitv, trial;
    gcd_pkg::val_t x_reg;
    logic flip_reg;

    assign bitv = 64'd1 << {step, 1'b0};
    assign trial = res_in + bitv;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_in;
            flip_reg <= flip_in;
            if (rem_in >= trial)
            begin
                rem_reg <= rem_in - trial;
                res_reg <= (res_in >> 1) + bitv;
            end
            else
            begin
                rem_reg <= rem_in;
                res_reg <= res_in >> 1;
            end
        end
    end
    assign rem_out = rem_reg;
    assign res_out = res_reg;
    assign x_out = x_reg;
    assign flip_out = flip_reg;
endmodule

@@ hw/rtl/gcd_checker.sv @@
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks on the distance block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gcd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [29:0] distance_miles
);
    `ASSERT_CLK(a_range, clk, rst_n, out_valid |-> distance_miles <= 30'd815100000, "distance out of range")
    `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(distance_miles)), "stalled item changed")
    `ASSERT_CLK(a_ready, clk, rst_n, (!out_valid || out_ready) |-> in_ready, "input blocked while output free")
    `ASSERT_ALWAYS(a_rst, clk, !rst_n |-> !out_valid, "valid during reset")
endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .distance_miles(out_ch.distance_miles)
);
